// File: hdl/tgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared types and constants for the turtle grid plotter.
// ----------------------------------------------------------------------------
package tgp_pkg;

  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = $clog2(GRID_SIZE);
  localparam int ROW_W     = 64;
  localparam int OP_W      = 3;
  localparam int STEP_W    = 8;
  localparam int ROW_IDX_W = 6;

  localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(GRID_SIZE - 1);

  typedef enum logic [OP_W-1:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_TURN_R   = 3'd2,
    OP_TURN_L   = 3'd3,
    OP_MOVE     = 3'd4,
    OP_PRINT    = 3'd5,
    OP_HALT     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    HEAD_EAST  = 2'd0,
    HEAD_SOUTH = 2'd1,
    HEAD_WEST  = 2'd2,
    HEAD_NORTH = 2'd3
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MARK,
    ST_PRT_RD,
    ST_PRT_LD
  } state_t;

  typedef struct packed {
    logic               rd_en;
    logic [COORD_W-1:0] rd_addr;
    logic               wr_en;
    logic [COORD_W-1:0] wr_addr;
    logic [ROW_W-1:0]   wr_data;
  } cnv_req_t;

endpackage

// File: hdl/tgp_canvas.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_canvas
// Canvas row memory with registered read and per-row valid bits cleared at
// reset; an unwritten row reads as all zero.
// ----------------------------------------------------------------------------
module tgp_canvas (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tgp_pkg::cnv_req_t          req,
  output logic [tgp_pkg::ROW_W-1:0]  rd_row
);

  logic [tgp_pkg::ROW_W-1:0]     mem [tgp_pkg::GRID_SIZE];
  logic [tgp_pkg::GRID_SIZE-1:0] row_vld_r;
  logic [tgp_pkg::ROW_W-1:0]     rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_addr];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

// File: hdl/turtle_grid_plotter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_grid_plotter_unit
// Turtle plotter on a 64 x 64 bit canvas held in a row memory.
//
// Input channel (in_valid / in_ready): one command request with in_operation
// and in_step_count. in_ready is high only while the sequencer is idle.
// Pen, turn, halt and ignored commands are done in the idle state. A move walks
// one cell per cycle with the pen up; with the pen down each cell takes a
// memory read, then a read-modify-write of the row. A move ends early at an
// edge. Print streams 64 rows on the result channel (out_valid / out_ready),
// each read through the single memory read port and then loaded into the
// output register, so the next row is read only after the last one is
// loaded. A stalled receiver holds the row in the output register and the
// sequencer waits. The next command can be taken while the last row is still
// waiting.
// After halt, commands are taken and ignored until reset. Reset returns the
// turtle to (0, 0) heading east with the pen up and clears the canvas at once
// through per-row valid bits.
// ----------------------------------------------------------------------------
module turtle_grid_plotter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tgp_pkg::OP_W-1:0]        in_operation,
  input  logic [tgp_pkg::STEP_W-1:0]      in_step_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tgp_pkg::ROW_IDX_W-1:0]   out_row_index,
  output logic [tgp_pkg::ROW_W-1:0]       out_row_cells,
  output logic                            out_last_row
);

  tgp_pkg::state_t               state_r, state_nxt;
  logic [tgp_pkg::COORD_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  tgp_pkg::head_t                heading_r, heading_nxt;
  logic                          pen_r, pen_nxt;
  logic                          halted_r, halted_nxt;
  logic [tgp_pkg::STEP_W-1:0]    steps_r, steps_nxt;
  logic [tgp_pkg::COORD_W-1:0]   prt_idx_r, prt_idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [tgp_pkg::ROW_IDX_W-1:0] out_row_index_r, out_row_index_nxt;
  logic [tgp_pkg::ROW_W-1:0]     out_row_cells_r, out_row_cells_nxt;
  logic                          out_last_row_r, out_last_row_nxt;

  logic                          accept;
  logic                          can_move;
  logic [tgp_pkg::COORD_W-1:0]   x_step, y_step;
  logic                          out_free;
  logic                          prt_last;
  tgp_pkg::op_t                  op;
  tgp_pkg::cnv_req_t             cnv_req;
  logic [tgp_pkg::ROW_W-1:0]     rd_row;

  tgp_canvas u_canvas (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cnv_req),
    .rd_row (rd_row)
  );

  assign in_ready = (state_r == tgp_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign op       = tgp_pkg::op_t'(in_operation);
  assign out_free = !out_valid_r || out_ready;
  assign prt_last = (prt_idx_r == tgp_pkg::COORD_LAST);

  // step unit for all four headings
  always_comb begin
    can_move = 1'b0;
    x_step   = x_r;
    y_step   = y_r;
    case (heading_r)
      tgp_pkg::HEAD_EAST: begin
        if (x_r != tgp_pkg::COORD_LAST) begin
          can_move = 1'b1;
          x_step   = x_r + 1'b1;
        end
      end
      tgp_pkg::HEAD_SOUTH: begin
        if (y_r != tgp_pkg::COORD_LAST) begin
          can_move = 1'b1;
          y_step   = y_r + 1'b1;
        end
      end
      tgp_pkg::HEAD_WEST: begin
        if (x_r != '0) begin
          can_move = 1'b1;
          x_step   = x_r - 1'b1;
        end
      end
      default: begin
        if (y_r != '0) begin
          can_move = 1'b1;
          y_step   = y_r - 1'b1;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgp_pkg::ST_IDLE: begin
        if (accept && !halted_r) begin
          case (op)
            tgp_pkg::OP_MOVE:  state_nxt = tgp_pkg::ST_STEP;
            tgp_pkg::OP_PRINT: state_nxt = tgp_pkg::ST_PRT_RD;
            default:           state_nxt = tgp_pkg::ST_IDLE;
          endcase
        end
      end
      tgp_pkg::ST_STEP: begin
        if (steps_r == '0 || !can_move) begin
          state_nxt = tgp_pkg::ST_IDLE;
        end else if (pen_r) begin
          state_nxt = tgp_pkg::ST_MARK;
        end
      end
      tgp_pkg::ST_MARK:   state_nxt = tgp_pkg::ST_STEP;
      tgp_pkg::ST_PRT_RD: state_nxt = tgp_pkg::ST_PRT_LD;
      tgp_pkg::ST_PRT_LD: begin
        if (out_free) begin
          state_nxt = prt_last ? tgp_pkg::ST_IDLE : tgp_pkg::ST_PRT_RD;
        end
      end
      default: state_nxt = tgp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    x_nxt             = x_r;
    y_nxt             = y_r;
    heading_nxt       = heading_r;
    pen_nxt           = pen_r;
    halted_nxt        = halted_r;
    steps_nxt         = steps_r;
    prt_idx_nxt       = prt_idx_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_row_index_nxt = out_row_index_r;
    out_row_cells_nxt = out_row_cells_r;
    out_last_row_nxt  = out_last_row_r;
    cnv_req           = '0;
    case (state_r)
      tgp_pkg::ST_IDLE: begin
        if (accept && !halted_r) begin
          steps_nxt   = in_step_count;
          prt_idx_nxt = '0;
          case (op)
            tgp_pkg::OP_PEN_UP:   pen_nxt     = 1'b0;
            tgp_pkg::OP_PEN_DOWN: pen_nxt     = 1'b1;
            tgp_pkg::OP_TURN_R:   heading_nxt = tgp_pkg::head_t'(2'(heading_r + 2'd1));
            tgp_pkg::OP_TURN_L:   heading_nxt = tgp_pkg::head_t'(2'(heading_r + 2'd3));
            tgp_pkg::OP_HALT:     halted_nxt  = 1'b1;
            default: ;
          endcase
        end
      end
      tgp_pkg::ST_STEP: begin
        if (steps_r != '0 && can_move) begin
          x_nxt     = x_step;
          y_nxt     = y_step;
          steps_nxt = steps_r - 1'b1;
          if (pen_r) begin
            cnv_req.rd_en   = 1'b1;
            cnv_req.rd_addr = x_step;
          end
        end
      end
      tgp_pkg::ST_MARK: begin
        cnv_req.wr_en   = 1'b1;
        cnv_req.wr_addr = x_r;
        cnv_req.wr_data = rd_row | (tgp_pkg::ROW_W'(1) << y_r);
      end
      tgp_pkg::ST_PRT_RD: begin
        cnv_req.rd_en   = 1'b1;
        cnv_req.rd_addr = prt_idx_r;
      end
      tgp_pkg::ST_PRT_LD: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_row_index_nxt = tgp_pkg::ROW_IDX_W'(prt_idx_r);
          out_row_cells_nxt = rd_row;
          out_last_row_nxt  = prt_last;
          prt_idx_nxt       = prt_idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tgp_pkg::ST_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      heading_r   <= tgp_pkg::HEAD_EAST;
      pen_r       <= 1'b0;
      halted_r    <= 1'b0;
      steps_r     <= '0;
      prt_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      heading_r   <= heading_nxt;
      pen_r       <= pen_nxt;
      halted_r    <= halted_nxt;
      steps_r     <= steps_nxt;
      prt_idx_r   <= prt_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_index_r <= out_row_index_nxt;
    out_row_cells_r <= out_row_cells_nxt;
    out_last_row_r  <= out_last_row_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_cells = out_row_cells_r;
  assign out_last_row  = out_last_row_r;

endmodule

// File: hdl/tgp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgp_checker
// Port-level checks for the turtle grid plotter, bound to the top level.
// ----------------------------------------------------------------------------
module tgp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tgp_pkg::ROW_IDX_W-1:0]   out_row_index,
  input logic [tgp_pkg::ROW_W-1:0]       out_row_cells,
  input logic                            out_last_row
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_row_index) && $stable(out_row_cells)
      && $stable(out_last_row))
    else $error("stalled result changed");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index ==
      tgp_pkg::ROW_IDX_W'(tgp_pkg::GRID_SIZE - 1))))
    else $error("last row flag does not match row index");

  a_busy_print: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |-> !in_ready)
    else $error("command request taken in the middle of a print");

endmodule

bind turtle_grid_plotter_unit tgp_checker u_tgp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row_index (out_row_index),
  .out_row_cells (out_row_cells),
  .out_last_row  (out_last_row)
);
